FILE: design/mbe_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared types and fixed constants: fixed-point format, register map,
// configuration record and the operand and product records of the
// shared multiplier unit.
// ----------------------------------------------------------------------------
package mbe_pkg;

	// Signed fixed point with this many fraction bits (Q4.28).
	localparam int FRAC_BITS  = 28;
	// Operand width of one multiplier lane and width of its full product.
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 2 * MUL_W;
	// Width of the iteration limit register and of the iteration counter.
	localparam int LIMIT_BITS = 16;
	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int START_W    = 32;
	localparam int STEP_W     = 31;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_REAL = 3'd0,
		CFG_START_IMAG = 3'd1,
		CFG_STEP_REAL  = 3'd2,
		CFG_STEP_IMAG  = 3'd3,
		CFG_ITER_LIMIT = 3'd4
	} cfg_idx_t;

	localparam logic [START_W-1:0]    RST_START_REAL = 32'hD800_0000; // -2.5
	localparam logic [START_W-1:0]    RST_START_IMAG = 32'hE800_0000; // -1.5
	localparam logic [STEP_W-1:0]     RST_STEP_REAL  = 31'd1342177;
	localparam logic [STEP_W-1:0]     RST_STEP_IMAG  = 31'd1342177;
	localparam logic [LIMIT_BITS-1:0] RST_ITER_LIMIT = 16'd1000;

	typedef struct packed {
		logic [START_W-1:0]    start_real;
		logic [START_W-1:0]    start_imag;
		logic [STEP_W-1:0]     step_real;
		logic [STEP_W-1:0]     step_imag;
		logic [LIMIT_BITS-1:0] iteration_limit;
	} cfg_t;

	// Three operand pairs presented to the multiplier unit in one cycle.
	typedef struct packed {
		logic signed [MUL_W-1:0] a0;
		logic signed [MUL_W-1:0] b0;
		logic signed [MUL_W-1:0] a1;
		logic signed [MUL_W-1:0] b1;
		logic signed [MUL_W-1:0] a2;
		logic signed [MUL_W-1:0] b2;
	} mul_req_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] p0;
		logic signed [PROD_W-1:0] p1;
		logic signed [PROD_W-1:0] p2;
	} mul_res_t;

endpackage

FILE: design/mbe_cfg_regs.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time configuration registers
// Holds the view origin, the per-pixel steps and the iteration limit.
// Writes to an index beyond the register map are dropped.
// ----------------------------------------------------------------------------
module mbe_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [mbe_pkg::CFG_DATA_W-1:0] wr_data,
	output mbe_pkg::cfg_t                  cfg
);
	import mbe_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_real      <= RST_START_REAL;
			cfg_q.start_imag      <= RST_START_IMAG;
			cfg_q.step_real       <= RST_STEP_REAL;
			cfg_q.step_imag       <= RST_STEP_IMAG;
			cfg_q.iteration_limit <= RST_ITER_LIMIT;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_START_REAL: cfg_q.start_real      <= wr_data[START_W-1:0];
				CFG_START_IMAG: cfg_q.start_imag      <= wr_data[START_W-1:0];
				CFG_STEP_REAL:  cfg_q.step_real       <= wr_data[STEP_W-1:0];
				CFG_STEP_IMAG:  cfg_q.step_imag       <= wr_data[STEP_W-1:0];
				CFG_ITER_LIMIT: cfg_q.iteration_limit <= wr_data[LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/mbe_mul_unit.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time multiplier unit
// Three signed 32 x 32 multipliers with registered full-width products.
// Used for the pixel-to-point mapping and then for every iteration.
// ----------------------------------------------------------------------------
module mbe_mul_unit (
	input  logic              clk,
	input  mbe_pkg::mul_req_t req,
	output mbe_pkg::mul_res_t res
);
	import mbe_pkg::*;

	mul_res_t res_q;

	always_ff @(posedge clk) begin
		res_q.p0 <= PROD_W'($signed(req.a0) * $signed(req.b0));
		res_q.p1 <= PROD_W'($signed(req.a1) * $signed(req.b1));
		res_q.p2 <= PROD_W'($signed(req.a2) * $signed(req.b2));
	end

	assign res = res_q;

endmodule

FILE: design/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel evaluator
// Maps a pixel to c = start + pixel * step and counts the iterations of
// z = z*z + c, starting from z = c, until |z|^2 exceeds 4 or the limit is hit.
// ----------------------------------------------------------------------------
//
//  channel  handshake            word
//  -------  -------------------  ------------------------------------------
//  in       in_valid / in_stall  pixel_col, pixel_row
//  out      out_valid/out_stall  out_col, out_row, iterations, inside_set
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// From acceptance to result, a setup step forms the pixel products, a load
// step forms c, and every iteration done (at most the limit) passes through
// the shared multiplier unit and then the add and escape-compare step.
// in_stall is high from acceptance until the result is loaded into the output
// register; a result that is waiting there does not block the next word.
// Reset leaves the configuration registers at their documented defaults and
// the block empty. cfg_ready is always high.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
	parameter int PIXEL_BITS = 11,
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [PIXEL_BITS-1:0]          pixel_col,
	input  logic [PIXEL_BITS-1:0]          pixel_row,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [PIXEL_BITS-1:0]          out_col,
	output logic [PIXEL_BITS-1:0]          out_row,
	output logic [COUNT_BITS-1:0]          iterations,
	output logic                           inside_set,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mbe_pkg::*;

	// The point c needs room for start plus pixel times step before the first
	// bound check; inside the loop every value is far smaller than this.
	localparam int CW = PIXEL_BITS + STEP_W + 2;

	localparam logic signed [CW-1:0] TWO_LIM  = CW'(64'sd2 <<< FRAC_BITS);
	localparam logic signed [CW-1:0] FOUR_LIM = CW'(64'sd4 <<< FRAC_BITS);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SETUP = 6'b000010,
		ST_LOADC = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_UPD   = 6'b010000,
		ST_HOLD  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	cfg_t     cfg;
	mul_req_t mreq;
	mul_res_t mres;

	logic [PIXEL_BITS-1:0] col_q, row_q;
	logic signed [CW-1:0]  c_re_q, c_im_q, x_q, y_q;
	logic [LIMIT_BITS-1:0] count_q;

	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] out_col_q, out_row_q;
	logic [COUNT_BITS-1:0] out_iter_q;
	logic                  out_inside_q;

	logic signed [CW-1:0] c_re_nx, c_im_nx;
	logic signed [CW-1:0] sq_x, sq_y, xy2, mag_sum, x_nx, y_nx;
	logic                 out_of_bounds, escaped, at_limit, out_free;
	logic                 accept, finish, load_out;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	mbe_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The multiplier unit forms pixel times step in the setup cycle and the
	// three products x*x, y*y and x*y in every iteration.
	always_comb begin
		if (state_q == ST_SETUP) begin
			mreq.a0 = $signed(MUL_W'(col_q));
			mreq.b0 = $signed(MUL_W'(cfg.step_real));
			mreq.a1 = $signed(MUL_W'(row_q));
			mreq.b1 = $signed(MUL_W'(cfg.step_imag));
		end else begin
			mreq.a0 = $signed(x_q[MUL_W-1:0]);
			mreq.b0 = $signed(x_q[MUL_W-1:0]);
			mreq.a1 = $signed(y_q[MUL_W-1:0]);
			mreq.b1 = $signed(y_q[MUL_W-1:0]);
		end
		mreq.a2 = $signed(x_q[MUL_W-1:0]);
		mreq.b2 = $signed(y_q[MUL_W-1:0]);
	end

	mbe_mul_unit u_mul (
		.clk (clk),
		.req (mreq),
		.res (mres)
	);

	// c from the pixel products registered in the setup cycle.
	assign c_re_nx = CW'($signed(cfg.start_real)) + CW'($signed(mres.p0));
	assign c_im_nx = CW'($signed(cfg.start_imag)) + CW'($signed(mres.p1));

	// Products scaled back to the fixed-point format, rounding towards minus
	// infinity. The cross term is doubled by shifting one bit less.
	assign sq_x = CW'($signed(mres.p0) >>> FRAC_BITS);
	assign sq_y = CW'($signed(mres.p1) >>> FRAC_BITS);
	assign xy2  = CW'($signed(mres.p2) >>> (FRAC_BITS - 1));

	assign mag_sum = sq_x + sq_y;
	assign escaped = mag_sum > FOUR_LIM;
	assign x_nx    = sq_x - sq_y + c_re_q;
	assign y_nx    = xy2 + c_im_q;

	// A coordinate beyond 2.0 in magnitude escapes at once. This also keeps
	// the multiplier operands within 32 bits whenever a product is used.
	assign out_of_bounds = (x_q > TWO_LIM) || (x_q < -TWO_LIM) ||
	                       (y_q > TWO_LIM) || (y_q < -TWO_LIM);
	assign at_limit      = count_q >= cfg.iteration_limit;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && !in_stall;

	// Sequencer.
	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_SETUP;
			end
			ST_SETUP: state_d = ST_LOADC;
			ST_LOADC: state_d = ST_MUL;
			ST_MUL: begin
				if (at_limit || out_of_bounds) finish = 1'b1;
				else state_d = ST_UPD;
			end
			ST_UPD: begin
				if (escaped) finish = 1'b1;
				else state_d = ST_MUL;
			end
			ST_HOLD: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (finish) state_d = out_free ? ST_IDLE : ST_HOLD;
	end

	assign load_out = (finish || state_q == ST_HOLD) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Working registers of the current pixel.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= pixel_col;
			row_q <= pixel_row;
		end
		if (state_q == ST_LOADC) begin
			c_re_q  <= c_re_nx;
			c_im_q  <= c_im_nx;
			x_q     <= c_re_nx;
			y_q     <= c_im_nx;
			count_q <= '0;
		end else if (state_q == ST_UPD && !escaped) begin
			x_q     <= x_nx;
			y_q     <= y_nx;
			count_q <= count_q + LIMIT_BITS'(1);
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_col_q    <= col_q;
			out_row_q    <= row_q;
			out_iter_q   <= COUNT_BITS'(count_q);
			out_inside_q <= at_limit;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_col    = out_col_q;
	assign out_row    = out_row_q;
	assign iterations = out_iter_q;
	assign inside_set = out_inside_q;

	// The iteration counter never passes the limit while a pixel is worked on.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_UPD) |-> count_q <= cfg.iteration_limit)
		else $error("iteration count beyond limit");

	// Products are only combined for a point that passed the bound check.
	a_upd_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |-> !out_of_bounds)
		else $error("update step with coordinate beyond 2.0");

	// An accepted word starts the setup cycle next.
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SETUP)
		else $error("accepted word did not start setup");

	// A finished pixel never overwrites a result still waiting to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !(out_valid_q && out_stall))
		else $error("output word overwritten while stalled");

endmodule

FILE: verif/tb_mandelbrot_escape_time_pixel.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel evaluator testbench
// Feeds pixel words through the block, sets the view, step and iteration
// limit between phases, and checks every result word against a table value
// or an in-house fixed-point escape-time calculation. A directed table comes
// first, then randomly shaped views with random pixels, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time_pixel;
	import mbe_pkg::*;

	localparam int PIX_W       = 11;
	localparam int CNT_W       = LIMIT_BITS;
	localparam int RESET_LEN   = 12;
	// Generous bound on the length of a correct run.
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int DRAIN_TAIL  = 16;
	localparam int MAX_REPORTS = 10;
	localparam int PHASES      = 10;
	localparam int PHASE_PIXELS = 60;

	// Fixed-point 2.0 and 4.0 in the block's format.
	localparam logic signed [63:0] FX_TWO  = 64'sd1 <<< (FRAC_BITS + 1);
	localparam logic signed [63:0] FX_FOUR = 64'sd1 <<< (FRAC_BITS + 2);

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_PIXEL,
		ROW_PIXEL_KNOWN
	} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		logic [PIX_W-1:0]     col;
		logic [PIX_W-1:0]     row;
		logic [CNT_W-1:0]     iterations;
		logic                 in_set;
	} stim_row_t;

	typedef struct packed {
		logic [PIX_W-1:0] col;
		logic [PIX_W-1:0] row;
		logic [CNT_W-1:0] iterations;
		logic             in_set;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [PIX_W-1:0] pixel_col;
	logic [PIX_W-1:0] pixel_row;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PIX_W-1:0] out_col;
	logic [PIX_W-1:0] out_row;
	logic [CNT_W-1:0] iterations;
	logic inside_set;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Our own copy of the view registers, updated as each write is taken.
	logic signed [START_W-1:0] view_start_re;
	logic signed [START_W-1:0] view_start_im;
	logic [STEP_W-1:0]         view_step_re;
	logic [STEP_W-1:0]         view_step_im;
	logic [CNT_W-1:0]          iter_limit;

	pixel_result_t pixels_in_flight[$];
	stim_row_t     directed_rows[$];
	int            fault_count = 0;
	int            cycle_count = 0;
	int            stall_left  = 0;
	logic          writing     = 1'b0;
	logic          no_gaps     = 1'b0;

	mandelbrot_escape_time_pixel #(
		.PIXEL_BITS(PIX_W),
		.COUNT_BITS(CNT_W)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_col (pixel_col),
		.pixel_row (pixel_row),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_col   (out_col),
		.out_row   (out_row),
		.iterations(iterations),
		.inside_set(inside_set),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Escape-time count for one pixel under the current view. Products are
	// taken at full width and floored back to the fixed-point format; the
	// term 2xy keeps one more fraction bit in the shift. Anything beyond 2.0
	// on either axis escapes before it is squared, so nothing can overflow.
	function automatic pixel_result_t escape_time(input logic [PIX_W-1:0] col,
			input logic [PIX_W-1:0] row);
		logic signed [63:0]  c_re, c_im, x, y, x_sq, y_sq, x_next;
		logic signed [127:0] prod;
		int unsigned         count;
		logic                escaped;
		pixel_result_t       res;
		c_re = {{32{view_start_re[START_W-1]}}, view_start_re} + 64'(col) * 64'(view_step_re);
		c_im = {{32{view_start_im[START_W-1]}}, view_start_im} + 64'(row) * 64'(view_step_im);
		x = c_re;
		y = c_im;
		count = 0;
		escaped = 1'b0;
		while (!escaped && count < 32'(iter_limit)) begin
			if (x > FX_TWO || x < -FX_TWO || y > FX_TWO || y < -FX_TWO) begin
				escaped = 1'b1;
			end else begin
				prod = x * x;
				x_sq = 64'(prod >>> FRAC_BITS);
				prod = y * y;
				y_sq = 64'(prod >>> FRAC_BITS);
				// Landing exactly on 4.0 still counts as bounded.
				if (x_sq + y_sq > FX_FOUR) begin
					escaped = 1'b1;
				end else begin
					x_next = x_sq - y_sq + c_re;
					prod = x * y;
					y = 64'(prod >>> (FRAC_BITS - 1)) + c_im;
					x = x_next;
					count++;
				end
			end
		end
		res.col = col;
		res.row = row;
		res.iterations = CNT_W'(count);
		res.in_set = (count >= 32'(iter_limit));
		return res;
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		return '{ROW_WRITE, idx, data, '0, '0, '0, 1'b0};
	endfunction

	function automatic stim_row_t pix(input int col, input int row);
		return '{ROW_PIXEL, '0, '0, PIX_W'(col), PIX_W'(row), '0, 1'b0};
	endfunction

	function automatic stim_row_t pix_known(input int col, input int row,
			input int count, input logic in_set);
		return '{ROW_PIXEL_KNOWN, '0, '0, PIX_W'(col), PIX_W'(row), CNT_W'(count),
			in_set};
	endfunction

	// Mostly back-to-back or short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// Lower the pixel valid and wait until every result word is back, so the
	// block is idle before its registers are touched.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pixels_in_flight.size() != 0);
	endtask

	// Register writes in a batch keep cfg_valid high between them; it is
	// lowered when the next pixel word goes out.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		if (!writing)
			wait_drained();
		writing = 1'b1;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_START_REAL: view_start_re = data;
			CFG_START_IMAG: view_start_im = data;
			CFG_STEP_REAL:  view_step_re  = data[STEP_W-1:0];
			CFG_STEP_IMAG:  view_step_im  = data[STEP_W-1:0];
			CFG_ITER_LIMIT: iter_limit    = data[CNT_W-1:0];
			default: ;
		endcase
	endtask

	// A word that follows straight on keeps valid high and only swaps the
	// payload at the edge where the previous one was taken.
	task automatic send_pixel(input stim_row_t r);
		int gap;
		pixel_result_t want;
		gap = pick_gap();
		if (writing) begin
			cfg_valid <= 1'b0;
			writing = 1'b0;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		pixel_col <= r.col;
		pixel_row <= r.row;
		do @(posedge clk); while (in_stall);
		if (r.kind == ROW_PIXEL_KNOWN)
			want = '{r.col, r.row, r.iterations, r.in_set};
		else
			want = escape_time(r.col, r.row);
		pixels_in_flight.push_back(want);
	endtask

	task automatic apply_row(input stim_row_t r);
		if (r.kind == ROW_WRITE)
			write_reg(r.idx, r.data);
		else
			send_pixel(r);
	endtask

	// Output stall: runs of random length, short ones mostly, with the odd
	// long stall and long stretches of no stalling at all.
	always @(posedge clk) begin
		int r;
		if (stall_left == 0) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				out_stall <= 1'b0;
				stall_left = $urandom_range(1, 8);
			end else if (r < 85) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(1, 4);
			end else if (r < 95) begin
				out_stall <= 1'b0;
				stall_left = $urandom_range(50, 300);
			end else begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(20, 60);
			end
		end else begin
			stall_left--;
		end
	end

	// Result checker: every word taken is held against the oldest pixel
	// still waiting for its answer.
	always @(posedge clk) begin
		pixel_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_col, out_row, iterations, inside_set};
			if (pixels_in_flight.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("unexpected result word: col %0d row %0d iterations %0d inside %0b",
						got.col, got.row, got.iterations, got.in_set);
			end else begin
				want = pixels_in_flight.pop_front();
				if (got.col !== want.col || got.row !== want.row
						|| got.iterations !== want.iterations || got.in_set !== want.in_set) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("wrong result: expected col %0d row %0d iterations %0d inside %0b, got col %0d row %0d iterations %0d inside %0b",
							want.col, want.row, want.iterations, want.in_set,
							got.col, got.row, got.iterations, got.in_set);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] s_re, s_im, st_re, st_im, lim_word;
		int shape;
		int lim;
		logic [PIX_W-1:0] col, row;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		pixel_col = '0;
		pixel_row = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		view_start_re = RST_START_REAL;
		view_start_im = RST_START_IMAG;
		view_step_re  = RST_STEP_REAL;
		view_step_im  = RST_STEP_IMAG;
		iter_limit    = RST_ITER_LIMIT;

		// Directed table. Straight after reset the view spans about -2.5..7.7 by
		// -1.5..8.7 in steps of about 1/200: the corners escape at once and pixel
		// (500, 300) sits next to the origin, so it must run to the full limit.
		directed_rows.push_back(pix_known(0, 0, 0, 1'b0));
		directed_rows.push_back(pix_known(2047, 2047, 0, 1'b0));
		directed_rows.push_back(pix_known(500, 300, 1000, 1'b1));
		directed_rows.push_back(pix(2047, 0));
		directed_rows.push_back(pix(0, 2047));
		directed_rows.push_back(pix(400, 300));
		directed_rows.push_back(pix(350, 250));
		// A zero limit reports no iterations and inside, even far outside.
		directed_rows.push_back(reg_row(CFG_ITER_LIMIT, 32'h0000_0000));
		directed_rows.push_back(pix_known(500, 300, 0, 1'b1));
		directed_rows.push_back(pix_known(0, 0, 0, 1'b1));
		// Limit of one; the upper half of the data word must be ignored.
		directed_rows.push_back(reg_row(CFG_ITER_LIMIT, 32'hFFFF_0001));
		directed_rows.push_back(pix_known(500, 300, 1, 1'b1));
		directed_rows.push_back(pix_known(0, 0, 0, 1'b0));
		// c = -2 exactly: z sits on 2.0 with |z|^2 equal to 4.0 and keeps
		// iterating. The top bit of a step word is dropped.
		directed_rows.push_back(reg_row(CFG_START_REAL, 32'hE000_0000));
		directed_rows.push_back(reg_row(CFG_START_IMAG, 32'h0000_0000));
		directed_rows.push_back(reg_row(CFG_STEP_REAL, 32'h0000_0000));
		directed_rows.push_back(reg_row(CFG_STEP_IMAG, 32'h8000_0000));
		directed_rows.push_back(reg_row(CFG_ITER_LIMIT, 32'd37));
		directed_rows.push_back(pix(0, 0));
		directed_rows.push_back(pix(2047, 2047));
		// c = 2i: on the boundary for one iteration, then off to -4.
		directed_rows.push_back(reg_row(CFG_START_REAL, 32'h0000_0000));
		directed_rows.push_back(reg_row(CFG_START_IMAG, 32'h2000_0000));
		directed_rows.push_back(pix(5, 6));
		// Just beyond 2.0 on the real axis escapes without a squaring.
		directed_rows.push_back(reg_row(CFG_START_REAL, 32'h2000_0001));
		directed_rows.push_back(pix_known(0, 0, 0, 1'b0));
		// Extreme starts and steps with the largest limit.
		directed_rows.push_back(reg_row(CFG_START_REAL, 32'h7FFF_FFFF));
		directed_rows.push_back(reg_row(CFG_START_IMAG, 32'h8000_0000));
		directed_rows.push_back(reg_row(CFG_STEP_REAL, 32'hFFFF_FFFF));
		directed_rows.push_back(reg_row(CFG_STEP_IMAG, 32'h7FFF_FFFF));
		directed_rows.push_back(reg_row(CFG_ITER_LIMIT, 32'h0000_FFFF));
		directed_rows.push_back(pix_known(0, 0, 0, 1'b0));
		directed_rows.push_back(pix_known(2047, 2047, 0, 1'b0));
		directed_rows.push_back(reg_row(CFG_START_REAL, 32'h8000_0000));
		directed_rows.push_back(pix_known(0, 2047, 0, 1'b0));
		// The origin under the largest limit: one long run to saturation.
		directed_rows.push_back(reg_row(CFG_START_REAL, 32'h0000_0000));
		directed_rows.push_back(reg_row(CFG_START_IMAG, 32'h0000_0000));
		directed_rows.push_back(reg_row(CFG_STEP_REAL, 32'h0000_0000));
		directed_rows.push_back(reg_row(CFG_STEP_IMAG, 32'h0000_0000));
		directed_rows.push_back(pix_known(2047, 0, 65535, 1'b1));
		// Writes to indexes beyond the register map must change nothing; a
		// value of 4.0 would push any start register out of the set.
		directed_rows.push_back(reg_row(CFG_ITER_LIMIT, 32'd3));
		for (int i = int'(CFG_ITER_LIMIT) + 1; i < 2 ** CFG_IDX_W; i++)
			directed_rows.push_back(reg_row(CFG_IDX_W'(i), 32'h4000_0000));
		directed_rows.push_back(pix_known(2047, 2047, 3, 1'b1));

		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			apply_row(directed_rows[i]);

		// Random phases: mostly views laid over the interesting part of the
		// plane, some pure noise, some with every pixel on one point.
		for (int phase = 0; phase < PHASES; phase++) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			shape = $urandom_range(0, 9);
			if (shape < 7) begin
				s_re = 32'h0 - $urandom_range(32'h0800_0000, 32'h2800_0000);
				s_im = 32'h0 - $urandom_range(0, 32'h1800_0000);
				if ($urandom_range(0, 3) == 0) begin
					st_re = $urandom_range(0, 4096);
					st_im = $urandom_range(0, 4096);
				end else begin
					st_re = $urandom_range(0, 32'h0007_0000);
					st_im = $urandom_range(0, 32'h0007_0000);
				end
			end else if (shape < 9) begin
				s_re  = $urandom();
				s_im  = $urandom();
				st_re = $urandom();
				st_im = $urandom();
			end else begin
				s_re  = 32'h0 - $urandom_range(0, 32'h2000_0000);
				s_im  = $urandom_range(0, 32'h0200_0000);
				st_re = 32'h0;
				st_im = 32'h0;
			end
			st_re[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
			st_im[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 4) == 0)
				lim = $urandom_range(49, 400);
			else
				lim = $urandom_range(1, 48);
			lim_word = {16'($urandom()), 16'(lim)};

			apply_row(reg_row(CFG_START_REAL, s_re));
			apply_row(reg_row(CFG_START_IMAG, s_im));
			apply_row(reg_row(CFG_STEP_REAL, st_re));
			apply_row(reg_row(CFG_STEP_IMAG, st_im));
			apply_row(reg_row(CFG_ITER_LIMIT, lim_word));

			for (int n = 0; n < PHASE_PIXELS; n++) begin
				col = PIX_W'($urandom());
				row = PIX_W'($urandom());
				if ($urandom_range(0, 15) == 0)
					col = $urandom_range(0, 1) ? '1 : '0;
				if ($urandom_range(0, 15) == 0)
					row = $urandom_range(0, 1) ? '1 : '0;
				apply_row(pix(int'(col), int'(row)));
			end
		end

		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (fault_count == 0 && pixels_in_flight.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: files.f
design/mbe_pkg.sv
design/mbe_cfg_regs.sv
design/mbe_mul_unit.sv
design/mandelbrot_escape_time_pixel.sv
verif/tb_mandelbrot_escape_time_pixel.sv
